// ===== hw/rtl/sss_pkg.sv =====
// Shared types, character codes and lexing functions for the SQL statement splitter.
// Used by sss_lexer, sss_queue, sql_statement_splitter, sss_checker and tb_top; depends on nothing.
`default_nettype none

package sss_pkg;

  // Lexical modes, also used as region codes on the result word.
  localparam logic [2:0] MODE_CODE  = 3'd0;
  localparam logic [2:0] MODE_SQ    = 3'd1;
  localparam logic [2:0] MODE_DQ    = 3'd2;
  localparam logic [2:0] MODE_LINE  = 3'd3;
  localparam logic [2:0] MODE_BLOCK = 3'd4;

  // Characters that drive the lexer.
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // Default depth of the result queue; a byte can push two words.
  localparam int QUEUE_DEPTH = 4;

  // One result word.
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] region;
    logic       sep;
    logic       empty;
    logic       done;
  } result_t;

  // Outcome of classifying one byte.
  typedef struct packed {
    logic       pair;
    logic       sep;
    logic [2:0] region;
    logic [2:0] mode_nxt;
  } lex_t;

  // Content tracking outcome for one emitted byte.
  typedef struct packed {
    logic empty;
    logic hc_nxt;
  } emit_t;

  // Words pushed into the result queue in one cycle, oldest first.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  function automatic logic is_ws(input logic [7:0] c);
    return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
  endfunction

  // Classify byte c in mode, with optional lookahead byte nx.
  function automatic lex_t lex_f(input logic [2:0] mode, input logic [7:0] c,
                                 input logic has_next, input logic [7:0] nx);
    lex_t       r;
    logic [2:0] m;
    m = (mode > MODE_BLOCK) ? MODE_CODE : mode;
    r.pair     = 1'b0;
    r.sep      = 1'b0;
    r.region   = m;
    r.mode_nxt = m;
    priority if (m == MODE_LINE) begin
      if (c == CH_NL) r.mode_nxt = MODE_CODE;
    end else if (m == MODE_BLOCK) begin
      if (c == CH_STAR && has_next && nx == CH_SLASH) begin
        r.pair     = 1'b1;
        r.mode_nxt = MODE_CODE;
      end
    end else if (m == MODE_CODE && c == CH_DASH && has_next && nx == CH_DASH) begin
      r.pair     = 1'b1;
      r.region   = MODE_LINE;
      r.mode_nxt = MODE_LINE;
    end else if (m == MODE_CODE && c == CH_SLASH && has_next && nx == CH_STAR) begin
      r.pair     = 1'b1;
      r.region   = MODE_BLOCK;
      r.mode_nxt = MODE_BLOCK;
    end else if (c == CH_SQUOTE && m != MODE_DQ) begin
      r.region = MODE_SQ;
      if (m == MODE_SQ && has_next && nx == CH_SQUOTE) r.pair = 1'b1;
      else r.mode_nxt = (m == MODE_SQ) ? MODE_CODE : MODE_SQ;
    end else if (c == CH_DQUOTE && m != MODE_SQ) begin
      r.region = MODE_DQ;
      if (m == MODE_DQ && has_next && nx == CH_DQUOTE) r.pair = 1'b1;
      else r.mode_nxt = (m == MODE_DQ) ? MODE_CODE : MODE_DQ;
    end else if (m == MODE_CODE && c == CH_SEMI) begin
      r.sep = 1'b1;
    end else begin
      r.sep = 1'b0;
    end
    return r;
  endfunction

  // Update the statement content flag for one emitted byte.
  function automatic emit_t emit_f(input logic hc, input logic [7:0] c,
                                   input logic sep, input logic done);
    emit_t e;
    if (sep) begin
      e.empty  = ~hc;
      e.hc_nxt = 1'b0;
    end else begin
      e.hc_nxt = hc | ~is_ws(c);
      e.empty  = done & ~e.hc_nxt;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sss_lexer.sv =====
// Lexer state and per-byte classification for the SQL statement splitter.
// Depends on sss_pkg; pushes up to two result words per accepted byte.
`default_nettype none

module sss_lexer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      script_byte,
  input  wire logic            end_of_script,
  output sss_pkg::push_t       push
);

  logic [2:0] mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       hc_r, hc_nxt;

  sss_pkg::lex_t  l1, l2;
  sss_pkg::emit_t e1, e2;

  // Classify the held byte against the new one, or the new byte alone.
  always_comb begin
    mode_nxt       = mode_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    hc_nxt         = hc_r;
    push           = '0;
    l1 = sss_pkg::lex_f(mode_r, held_valid_r ? held_r : script_byte,
                        held_valid_r, script_byte);
    e1 = sss_pkg::emit_f(hc_r, held_valid_r ? held_r : script_byte,
                         l1.sep & ~l1.pair, ~held_valid_r);
    l2 = sss_pkg::lex_f(l1.mode_nxt, script_byte, 1'b0, 8'h00);
    e2 = sss_pkg::emit_f(e1.hc_nxt, script_byte, l1.pair ? 1'b0 : l2.sep,
                         end_of_script);

    if (accept) begin
      if (!held_valid_r) begin
        if (end_of_script) begin
          // Lone final byte: classified with no lookahead.
          push.push0 = 1'b1;
          push.res0  = '{data: script_byte, region: l1.region, sep: l1.sep,
                         empty: e1.empty, done: 1'b1};
        end else begin
          held_nxt       = script_byte;
          held_valid_nxt = 1'b1;
        end
      end else begin
        push.push0 = 1'b1;
        push.res0  = '{data: held_r, region: l1.region, sep: l1.sep & ~l1.pair,
                       empty: e1.empty, done: 1'b0};
        mode_nxt   = l1.mode_nxt;
        hc_nxt     = e1.hc_nxt;
        if (l1.pair) begin
          // Two-byte token: both bytes share the region.
          push.push1     = 1'b1;
          push.res1      = '{data: script_byte, region: l1.region, sep: 1'b0,
                             empty: e2.empty, done: end_of_script};
          hc_nxt         = e2.hc_nxt;
          held_valid_nxt = 1'b0;
          held_nxt       = '0;
        end else if (end_of_script) begin
          push.push1     = 1'b1;
          push.res1      = '{data: script_byte, region: l2.region, sep: l2.sep,
                             empty: e2.empty, done: 1'b1};
          held_valid_nxt = 1'b0;
        end else begin
          held_nxt = script_byte;
        end
      end
      // Script end returns the lexer to its reset state.
      if (end_of_script) begin
        mode_nxt       = sss_pkg::MODE_CODE;
        hc_nxt         = 1'b0;
        held_valid_nxt = 1'b0;
        held_nxt       = '0;
      end
    end
  end

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= sss_pkg::MODE_CODE;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      hc_r         <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      hc_r         <= hc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sss_queue.sv =====
// Result queue for the SQL statement splitter: takes up to two words a cycle.
// Depends on sss_pkg; presents the oldest word on a valid/ready port.
`default_nettype none

module sss_queue #(
  parameter int Depth = sss_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sss_pkg::push_t    push,
  output logic                   has_room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sss_pkg::result_t       out_res
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sss_pkg::result_t mem [Depth];

  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [PtrW-1:0] wr_ptr_p1;
  logic            pop;

  function automatic logic [PtrW-1:0] inc_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr_p1 = inc_ptr(wr_ptr_r);
  assign pop       = out_valid & out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = mem[rd_ptr_r];
  // Room for two words whatever the consumer does this cycle.
  assign has_room  = (count_r <= CntW'(Depth - 2));

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.push0 && push.push1) wr_ptr_nxt = inc_ptr(wr_ptr_p1);
    else if (push.push0 || push.push1) wr_ptr_nxt = wr_ptr_p1;
    rd_ptr_nxt = pop ? inc_ptr(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CntW'(push.push0) + CntW'(push.push1) - CntW'(pop);
  end

  // Storage writes; the second word lands behind the first.
  always_ff @(posedge clk) begin
    if (push.push0) mem[wr_ptr_r] <= push.res0;
    if (push.push1) mem[push.push0 ? wr_ptr_p1 : wr_ptr_r] <= push.res1;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sql_statement_splitter.sv =====
// SQL statement splitter top level: lexer plus result queue.
// A byte's word is written when the next byte is accepted, or with the byte itself if final;
// it is offered in the cycle after its write, behind older words; one word leaves per cycle on out_ready.
// Throughput: one byte per cycle while in_ready is high; a byte makes zero, one or two words.
// Reset (rst_n low, synchronous): code mode, nothing held, statement empty, queue empty.
// Depends on sss_pkg, sss_lexer and sss_queue.
`default_nettype none

module sql_statement_splitter #(
  parameter int QueueDepth = sss_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_script_byte,
  input  wire logic       in_end_of_script,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_out_byte,
  output logic [2:0]      out_region,
  output logic            out_is_separator,
  output logic            out_statement_empty,
  output logic            out_script_done
);

  sss_pkg::push_t   push;
  sss_pkg::result_t res;
  logic             accept;

  // A byte is taken only when the queue can hold both possible result words.
  assign accept = in_valid & in_ready;

  sss_lexer u_lexer (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .script_byte   (in_script_byte),
    .end_of_script (in_end_of_script),
    .push          (push)
  );

  sss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Unpack the result word onto the ports.
  assign out_out_byte        = res.data;
  assign out_region          = res.region;
  assign out_is_separator    = res.sep;
  assign out_statement_empty = res.empty;
  assign out_script_done     = res.done;

endmodule

`default_nettype wire

// ===== sim/sss_checker.sv =====
`timescale 1ns / 1ps
// Checker for sql_statement_splitter: watches the byte and word channels, predicts the result words
// from the accepted script bytes and compares them in order. Depends on sss_pkg.
module sss_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_script_byte,
  input  logic       in_end_of_script,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_out_byte,
  input  logic [2:0] out_region,
  input  logic       out_is_separator,
  input  logic       out_statement_empty,
  input  logic       out_script_done,
  output int         mismatch_count,
  output int         words_owed
);

  // Shadow copy of the splitter state.
  logic [2:0] lex_state;
  logic [7:0] pending_byte;
  logic       pending_vld;
  logic       stmt_has_text;

  // Result words still to come, oldest first.
  sss_pkg::result_t classified_words[$];

  initial begin
    mismatch_count = 0;
    words_owed     = 0;
  end

  function automatic bit blank_char(input logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
  endfunction

  // Queue one classified word and track whether the statement has content so far.
  task automatic log_word(input logic [7:0] c, input logic [2:0] region, input bit sep,
                          input bit done);
    sss_pkg::result_t w;
    w.data   = c;
    w.region = region;
    w.sep    = sep;
    w.done   = done;
    if (sep) begin
      w.empty       = !stmt_has_text;
      stmt_has_text = 1'b0;
    end else begin
      if (!blank_char(c)) stmt_has_text = 1'b1;
      w.empty = done && !stmt_has_text;
    end
    classified_words.push_back(w);
    // The end of a script puts everything back to the reset state.
    if (done) begin
      lex_state     = sss_pkg::MODE_CODE;
      stmt_has_text = 1'b0;
      pending_vld   = 1'b0;
      pending_byte  = 8'h00;
    end
  endtask

  // Classify byte c with optional lookahead nx; took_pair tells if nx was used up too.
  task automatic classify_byte(input logic [7:0] c, input bit has_next, input logic [7:0] nx,
                               input bit last, output bit took_pair);
    logic [2:0] m;
    logic [2:0] region;
    bit         pair;
    bit         sep;
    m      = (lex_state > sss_pkg::MODE_BLOCK) ? sss_pkg::MODE_CODE : lex_state;
    region = m;
    pair   = 1'b0;
    sep    = 1'b0;
    if (m == sss_pkg::MODE_LINE) begin
      if (c == sss_pkg::CH_NL) lex_state = sss_pkg::MODE_CODE;
    end else if (m == sss_pkg::MODE_BLOCK) begin
      if (c == sss_pkg::CH_STAR && has_next && nx == sss_pkg::CH_SLASH) begin
        pair      = 1'b1;
        lex_state = sss_pkg::MODE_CODE;
      end
    end else if (m == sss_pkg::MODE_CODE && c == sss_pkg::CH_DASH && has_next &&
                 nx == sss_pkg::CH_DASH) begin
      pair      = 1'b1;
      region    = sss_pkg::MODE_LINE;
      lex_state = sss_pkg::MODE_LINE;
    end else if (m == sss_pkg::MODE_CODE && c == sss_pkg::CH_SLASH && has_next &&
                 nx == sss_pkg::CH_STAR) begin
      pair      = 1'b1;
      region    = sss_pkg::MODE_BLOCK;
      lex_state = sss_pkg::MODE_BLOCK;
    end else if (c == sss_pkg::CH_SQUOTE && m != sss_pkg::MODE_DQ) begin
      region = sss_pkg::MODE_SQ;
      // A doubled quote inside the string is an escape.
      if (m == sss_pkg::MODE_SQ && has_next && nx == sss_pkg::CH_SQUOTE) pair = 1'b1;
      else lex_state = (m == sss_pkg::MODE_SQ) ? sss_pkg::MODE_CODE : sss_pkg::MODE_SQ;
    end else if (c == sss_pkg::CH_DQUOTE && m != sss_pkg::MODE_SQ) begin
      region = sss_pkg::MODE_DQ;
      if (m == sss_pkg::MODE_DQ && has_next && nx == sss_pkg::CH_DQUOTE) pair = 1'b1;
      else lex_state = (m == sss_pkg::MODE_DQ) ? sss_pkg::MODE_CODE : sss_pkg::MODE_DQ;
    end else if (m == sss_pkg::MODE_CODE && c == sss_pkg::CH_SEMI) begin
      sep = 1'b1;
    end
    if (pair) begin
      log_word(c, region, 1'b0, 1'b0);
      log_word(nx, region, 1'b0, last);
    end else begin
      log_word(c, region, sep, !has_next && last);
    end
    took_pair = pair;
  endtask

  // Advance the shadow state by one accepted script byte.
  task automatic predict_byte(input logic [7:0] b, input bit last);
    bit pair;
    if (!pending_vld) begin
      if (!last) begin
        pending_byte = b;
        pending_vld  = 1'b1;
      end else begin
        classify_byte(b, 1'b0, 8'h00, 1'b1, pair);
      end
    end else begin
      classify_byte(pending_byte, 1'b1, b, last, pair);
      if (pair) begin
        pending_vld  = 1'b0;
        pending_byte = 8'h00;
      end else if (last) begin
        pending_vld = 1'b0;
        classify_byte(b, 1'b0, 8'h00, 1'b1, pair);
      end else begin
        pending_byte = b;
        pending_vld  = 1'b1;
      end
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Compare each accepted result word, then fold in each accepted script byte.
  always @(posedge clk) begin : watch
    sss_pkg::result_t want;
    if (!rst_n) begin
      lex_state     = sss_pkg::MODE_CODE;
      pending_byte  = 8'h00;
      pending_vld   = 1'b0;
      stmt_has_text = 1'b0;
      classified_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (classified_words.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, expected none, actual %0h region %0d",
                   $time, out_out_byte, out_region);
        end else begin
          want = classified_words.pop_front();
          check_field("out_byte", want.data, out_out_byte);
          check_field("region", {5'd0, want.region}, {5'd0, out_region});
          check_field("is_separator", {7'd0, want.sep}, {7'd0, out_is_separator});
          check_field("statement_empty", {7'd0, want.empty}, {7'd0, out_statement_empty});
          check_field("script_done", {7'd0, want.done}, {7'd0, out_script_done});
        end
      end
      if (in_valid && in_ready) predict_byte(in_script_byte, in_end_of_script);
    end
    words_owed <= classified_words.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the sql_statement_splitter testbench: clock, reset, script stimulus and verdict.
// Depends on sss_pkg, the splitter RTL and sss_checker.
module tb_top;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_script_byte = 8'h00;
  logic       in_end_of_script = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic [2:0] out_region;
  logic       out_is_separator;
  logic       out_statement_empty;
  logic       out_script_done;

  int mismatch_count;
  int words_owed;

  // Script under construction and bytes sent in the current phase.
  logic [7:0] script_q[$];
  int         bytes_sent;
  bit         steady = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sql_statement_splitter u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_script_byte      (in_script_byte),
    .in_end_of_script    (in_end_of_script),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_out_byte        (out_out_byte),
    .out_region          (out_region),
    .out_is_separator    (out_is_separator),
    .out_statement_empty (out_statement_empty),
    .out_script_done     (out_script_done)
  );

  sss_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_script_byte      (in_script_byte),
    .in_end_of_script    (in_end_of_script),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_out_byte        (out_out_byte),
    .out_region          (out_region),
    .out_is_separator    (out_is_separator),
    .out_statement_empty (out_statement_empty),
    .out_script_done     (out_script_done),
    .mismatch_count      (mismatch_count),
    .words_owed          (words_owed)
  );

  // Idle cycles before the next word; none during steady stretches.
  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [7:0] pick_ws();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
  endfunction

  function automatic logic [7:0] pick_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: after each taken word, drop ready for a random number of cycles.
  always @(posedge clk) begin : sink_side
    int hold;
    if (rst_n) begin
      if (hold > 0) begin
        hold--;
      end else if (!out_ready) begin
        out_ready <= 1'b1;
      end else if (out_valid) begin
        hold = draw_gap();
        if (hold > 0) begin
          out_ready <= 1'b0;
          hold--;
        end
      end
    end else begin
      hold = 0;
    end
  end

  // Offer one script byte after a random gap and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_script_byte   <= b;
    in_end_of_script <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_script();
    int i;
    for (i = 0; i < script_q.size(); i++) send_byte(script_q[i], i == script_q.size() - 1);
    bytes_sent += script_q.size();
    script_q.delete();
  endtask

  // Append one lexical token to the script; some strings and comments stay open.
  task automatic add_token();
    int         kind;
    int         n;
    int         i;
    logic [7:0] c;
    logic [7:0] q;
    kind = $urandom_range(0, 9);
    n    = $urandom_range(0, 5);
    case (kind)
      0, 1: for (i = 0; i <= n; i++) script_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
      2: for (i = 0; i <= n; i++) script_q.push_back(pick_ws());
      3: script_q.push_back(sss_pkg::CH_SEMI);
      4, 5: begin
        q = (kind == 4) ? sss_pkg::CH_SQUOTE : sss_pkg::CH_DQUOTE;
        script_q.push_back(q);
        for (i = 0; i < n; i++) begin
          c = pick_byte();
          script_q.push_back(c);
          if (c == q) script_q.push_back(c);
        end
        if ($urandom_range(0, 5) != 0) script_q.push_back(q);
      end
      6: begin
        script_q.push_back(sss_pkg::CH_DASH);
        script_q.push_back(sss_pkg::CH_DASH);
        for (i = 0; i < n; i++) begin
          c = pick_byte();
          if (c != sss_pkg::CH_NL) script_q.push_back(c);
        end
        if ($urandom_range(0, 5) != 0) script_q.push_back(sss_pkg::CH_NL);
      end
      7: begin
        script_q.push_back(sss_pkg::CH_SLASH);
        script_q.push_back(sss_pkg::CH_STAR);
        for (i = 0; i < n; i++) script_q.push_back(pick_byte());
        if ($urandom_range(0, 5) != 0) begin
          script_q.push_back(sss_pkg::CH_STAR);
          script_q.push_back(sss_pkg::CH_SLASH);
        end
      end
      8: for (i = 0; i <= n; i++) script_q.push_back(pick_byte());
      default: begin
        case ($urandom_range(0, 5))
          0: script_q.push_back(sss_pkg::CH_DASH);
          1: script_q.push_back(sss_pkg::CH_SLASH);
          2: script_q.push_back(sss_pkg::CH_STAR);
          3: script_q.push_back(sss_pkg::CH_SQUOTE);
          4: script_q.push_back(sss_pkg::CH_DQUOTE);
          default: script_q.push_back(sss_pkg::CH_NL);
        endcase
      end
    endcase
  endtask

  initial begin : stimulus
    int n_tok;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: one-byte scripts, every delimiter, escapes and a pair at script end.
    script_q = '{sss_pkg::CH_SEMI};
    send_script();
    script_q = '{8'hFF};
    send_script();
    script_q = '{8'h00, sss_pkg::CH_DASH, sss_pkg::CH_DASH, sss_pkg::CH_NL,
                 sss_pkg::CH_SQUOTE, sss_pkg::CH_SQUOTE, sss_pkg::CH_SQUOTE,
                 sss_pkg::CH_SQUOTE, sss_pkg::CH_DQUOTE, sss_pkg::CH_DQUOTE,
                 sss_pkg::CH_DQUOTE, sss_pkg::CH_DQUOTE, sss_pkg::CH_SLASH, sss_pkg::CH_STAR,
                 sss_pkg::CH_STAR, sss_pkg::CH_SLASH, sss_pkg::CH_SEMI, 8'h09,
                 sss_pkg::CH_SEMI};
    send_script();
    script_q = '{8'h61, sss_pkg::CH_DASH, sss_pkg::CH_DASH};
    send_script();

    // Random scripts, mostly well formed, in stretches with and without idling.
    bytes_sent = 0;
    while (bytes_sent < 550) begin
      steady = ($urandom_range(0, 4) == 0);
      n_tok  = $urandom_range(1, 8);
      repeat (n_tok) add_token();
      send_script();
    end
    in_valid <= 1'b0;
    steady   = 1'b0;

    // Drain the outstanding words, then watch for stray ones.
    do @(posedge clk); while (words_owed != 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[sql_statement_splitter] OK");
    end else begin
      $display("[sql_statement_splitter] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[sql_statement_splitter] ERROR");
    $finish;
  end

endmodule

// ===== sql_statement_splitter.f =====
hw/rtl/sss_pkg.sv
hw/rtl/sss_lexer.sv
hw/rtl/sss_queue.sv
hw/rtl/sql_statement_splitter.sv
sim/sss_checker.sv
sim/tb_top.sv
